// ===== rtl/core/esma_pkg.sv =====
// ---------------------------------------------------------------------------
// esma_pkg: shared constants for the encoder speed moving average
// Field widths, register indexes, reset values and parameter defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esma_pkg;

  // item field widths
  localparam int CNT_W   = 16;  // counter_value
  localparam int DELTA_W = 18;  // count_delta
  localparam int SPEED_W = 34;  // filtered_speed, scaled speed entries
  localparam int WRAP_W  = 16;  // wrap counter
  localparam int CFG_W   = 16;  // configuration registers

  localparam int OUT_DATA_W = 56;  // count_delta + filtered_speed, padded to bytes

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] RST_RELOAD = 16'd20000;
  localparam logic [CFG_W-1:0] RST_THRESH = 16'd19000;
  localparam logic [CFG_W-1:0] RST_GAIN   = 16'd1;

  // parameter defaults
  localparam int HISTORY_DEPTH_DEF = 20;
  localparam int COUNT_WIDTH_DEF   = 16;

  // quotient bits resolved per divider cycle
  localparam int DIV_STEP = 8;

endpackage

`default_nettype wire

// ===== rtl/core/esma_hist.sv =====
// ---------------------------------------------------------------------------
// esma_hist: speed history memory
// One write and one registered read per cycle. Per-entry valid bits are
// cleared by reset; an entry never written reads as zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esma_hist #(
  parameter int DEPTH  = 20,
  parameter int DATA_W = 34
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [DATA_W-1:0] rd_q;
  logic              rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_vld <= valid[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/esma_div.sv =====
// ---------------------------------------------------------------------------
// esma_div: iterative unsigned division by a constant
// Long division, DIV_STEP quotient bits per cycle; remainder stays narrow.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esma_div #(
  parameter int DEPTH = 20,
  parameter int IN_W  = 39
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [IN_W-1:0] dividend,
  output logic                 done,
  output logic      [IN_W-1:0] quotient
);

  import esma_pkg::*;

  localparam int NCYC = (IN_W + DIV_STEP - 1) / DIV_STEP;
  localparam int NB   = NCYC * DIV_STEP;
  localparam int RW   = $clog2(DEPTH) + 1;
  localparam int CW   = $clog2(NCYC + 1);

  logic [NB-1:0] shreg;
  logic [NB-1:0] shreg_next;
  logic [RW-1:0] rem;
  logic [RW-1:0] rem_next;
  logic [CW-1:0] cnt;
  logic          busy;

  always_comb begin
    logic [RW:0] t;
    logic        qbit;
    rem_next   = rem;
    shreg_next = shreg;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {rem_next, shreg_next[NB-1]};
      qbit = 1'b0;
      if (t >= (RW+1)'(DEPTH)) begin
        t    = t - (RW+1)'(DEPTH);
        qbit = 1'b1;
      end
      rem_next   = t[RW-1:0];
      shreg_next = {shreg_next[NB-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= NB'(dividend);
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg_next;
      rem   <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NCYC);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = shreg[IN_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/encoder_speed_moving_average.sv =====
// ---------------------------------------------------------------------------
// encoder_speed_moving_average: wheel speed from a quadrature counter
// Extends the counter with a wrap count, scales the count delta by an unsigned
// 16-bit integer gain and averages the last HISTORY_DEPTH scaled speeds.
// ---------------------------------------------------------------------------
// One item per sampling tick in, one result per item out. Items are handled
// one at a time: the sequencer steps through MUL0, TOT0, MUL1, TOT1, SCALE,
// SUB, ADD, ABS and START, waits in DIV until the divider finishes and waits
// in DONE until the result register can take the result. The mean is the
// history sum divided by the depth in an 8-bit-per-cycle long divider,
// truncating toward zero. The history lives in a small memory whose entries
// read as zero until first written, so there is no clearing pass after
// reset. The result register lets a new item in while a result waits.
// Configuration writes are always taken and must happen while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module encoder_speed_moving_average #(
  parameter int HISTORY_DEPTH = esma_pkg::HISTORY_DEPTH_DEF,
  parameter int COUNT_WIDTH   = esma_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // input items
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  input  wire logic [esma_pkg::CNT_W-1:0]             s_tdata,  // [15:0] counter_value
  input  wire logic                                   s_tuser,  // [0] counting_down
  // result items
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // [17:0] count_delta, [51:18] filtered_speed, [55:52] zero
  output logic      [esma_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic                                        m_tuser,  // [0] direction
  // configuration writes
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [esma_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [esma_pkg::CFG_W-1:0]             cfg_data
);

  import esma_pkg::*;

  localparam int PTR_W  = $clog2(HISTORY_DEPTH);
  localparam int SUM_W  = SPEED_W + PTR_W;
  localparam int PROD_W = WRAP_W + CFG_W + 1;
  localparam int TOT_W  = PROD_W + 1;
  localparam int DIFF_W = TOT_W + 1;
  localparam int CNT_USED = (COUNT_WIDTH < CNT_W) ? COUNT_WIDTH : CNT_W;
  localparam logic [CNT_W:0] CNT_MASK = (CNT_W+1)'((1 << CNT_USED) - 1);
  localparam logic signed [DIFF_W-1:0] DELTA_MAX = DIFF_W'((1 << (DELTA_W-1)) - 1);
  localparam logic signed [DIFF_W-1:0] DELTA_MIN = -DIFF_W'(1 << (DELTA_W-1));

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] ST_MUL0  = 4'd1;
  localparam logic [ST_W-1:0] ST_TOT0  = 4'd2;
  localparam logic [ST_W-1:0] ST_MUL1  = 4'd3;
  localparam logic [ST_W-1:0] ST_TOT1  = 4'd4;
  localparam logic [ST_W-1:0] ST_SCALE = 4'd5;
  localparam logic [ST_W-1:0] ST_SUB   = 4'd6;
  localparam logic [ST_W-1:0] ST_ADD   = 4'd7;
  localparam logic [ST_W-1:0] ST_ABS   = 4'd8;
  localparam logic [ST_W-1:0] ST_START = 4'd9;
  localparam logic [ST_W-1:0] ST_DIV   = 4'd10;
  localparam logic [ST_W-1:0] ST_DONE  = 4'd11;

  // configuration
  logic [CFG_W-1:0] reload_value;
  logic [CFG_W-1:0] wrap_threshold;
  logic [CFG_W-1:0] speed_gain;

  // control and per-wheel state
  logic [ST_W-1:0]          state;
  logic [ST_W-1:0]          state_next;
  logic [WRAP_W-1:0]        wrap_count;
  logic [WRAP_W-1:0]        wrap_count_next;
  logic signed [TOT_W-1:0]  last_total;
  logic signed [SUM_W-1:0]  history_sum;
  logic [PTR_W-1:0]         history_pointer;

  // per-item working registers
  logic [CNT_W-1:0]          cnt_q;
  logic                      dir_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic signed [SPEED_W-1:0] scaled_q;
  logic [SUM_W-1:0]          mag_q;
  logic                      neg_q;

  // datapath
  logic signed [PROD_W-1:0]  wrap_ext;
  logic signed [PROD_W-1:0]  reload_ext;
  logic signed [PROD_W-1:0]  prod_full;
  logic signed [TOT_W-1:0]   total;
  logic signed [DIFF_W-1:0]  diff_fwd;
  logic signed [DIFF_W-1:0]  diff_back;
  logic signed [DIFF_W-1:0]  thr_ext;
  logic signed [DELTA_W-1:0] delta_sat;
  logic signed [SPEED_W-1:0] delta_ext;
  logic signed [SPEED_W-1:0] gain_ext;
  logic signed [SPEED_W-1:0] scaled_full;
  logic [SPEED_W-1:0]        old_speed;
  logic [SPEED_W-1:0]        quot_low;
  logic [SPEED_W-1:0]        speed_out;

  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_quot;
  logic             out_load;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign div_start = (state == ST_START);
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value   <= RST_RELOAD;
      wrap_threshold <= RST_THRESH;
      speed_gain     <= RST_GAIN;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RELOAD: reload_value   <= cfg_data;
        REG_THRESH: wrap_threshold <= cfg_data;
        REG_GAIN:   speed_gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    wrap_ext    = {{(PROD_W-WRAP_W){wrap_count[WRAP_W-1]}}, wrap_count};
    reload_ext  = {{(PROD_W-CFG_W){1'b0}}, reload_value};
    prod_full   = wrap_ext * reload_ext;
    total       = {{(TOT_W-CNT_W){1'b0}}, cnt_q} + {prod_q[PROD_W-1], prod_q};
    diff_fwd    = {total[TOT_W-1], total} - {last_total[TOT_W-1], last_total};
    diff_back   = {last_total[TOT_W-1], last_total} - {total[TOT_W-1], total};
    thr_ext     = {{(DIFF_W-CFG_W){1'b0}}, wrap_threshold};
    if (diff_fwd > DELTA_MAX) begin
      delta_sat = DELTA_MAX[DELTA_W-1:0];
    end else if (diff_fwd < DELTA_MIN) begin
      delta_sat = DELTA_MIN[DELTA_W-1:0];
    end else begin
      delta_sat = diff_fwd[DELTA_W-1:0];
    end
    delta_ext   = {{(SPEED_W-DELTA_W){delta_q[DELTA_W-1]}}, delta_q};
    gain_ext    = {{(SPEED_W-CFG_W){1'b0}}, speed_gain};
    scaled_full = delta_ext * gain_ext;
    quot_low    = div_quot[SPEED_W-1:0];
    speed_out   = neg_q ? (SPEED_W'(0) - quot_low) : quot_low;
  end

  // at most one wrap correction per item
  always_comb begin
    wrap_count_next = wrap_count;
    if (diff_back > thr_ext) begin
      wrap_count_next = wrap_count + WRAP_W'(1);
    end else if (diff_fwd > thr_ext) begin
      wrap_count_next = wrap_count - WRAP_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_MUL0;
      ST_MUL0:  state_next = ST_TOT0;
      ST_TOT0:  state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_TOT1;
      ST_TOT1:  state_next = ST_SCALE;
      ST_SCALE: state_next = ST_SUB;
      ST_SUB:   state_next = ST_ADD;
      ST_ADD:   state_next = ST_ABS;
      ST_ABS:   state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      wrap_count      <= '0;
      last_total      <= '0;
      history_sum     <= '0;
      history_pointer <= '0;
    end else begin
      state <= state_next;
      if (state == ST_TOT0) begin
        wrap_count <= wrap_count_next;
      end
      if (state == ST_TOT1) begin
        last_total <= total;
      end
      if (state == ST_SUB) begin
        history_sum <= history_sum - {{(SUM_W-SPEED_W){old_speed[SPEED_W-1]}}, old_speed};
      end
      if (state == ST_ADD) begin
        history_sum <= history_sum + {{(SUM_W-SPEED_W){scaled_q[SPEED_W-1]}}, scaled_q};
        if (history_pointer == PTR_W'(HISTORY_DEPTH - 1)) begin
          history_pointer <= '0;
        end else begin
          history_pointer <= history_pointer + PTR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cnt_q <= s_tdata & CNT_MASK[CNT_W-1:0];
      dir_q <= s_tuser;
    end
    if (state == ST_MUL0 || state == ST_MUL1) begin
      prod_q <= prod_full;
    end
    if (state == ST_TOT1) begin
      delta_q <= delta_sat;
    end
    if (state == ST_SCALE) begin
      scaled_q <= scaled_full;
    end
    if (state == ST_ABS) begin
      mag_q <= history_sum[SUM_W-1] ? (SUM_W'(0) - history_sum) : history_sum;
      neg_q <= history_sum[SUM_W-1];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {(OUT_DATA_W-SPEED_W-DELTA_W)'(0), speed_out, delta_q};
      m_tuser <= dir_q;
    end
  end

  esma_hist #(
    .DEPTH  (HISTORY_DEPTH),
    .DATA_W (SPEED_W)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (history_pointer),
    .rd_data (old_speed),
    .wr_en   (state == ST_ADD),
    .wr_addr (history_pointer),
    .wr_data (scaled_q)
  );

  esma_div #(
    .DEPTH (HISTORY_DEPTH),
    .IN_W  (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_q),
    .done     (div_done),
    .quotient (div_quot)
  );

endmodule

`default_nettype wire
